FILE: rtl/rlmt_pkg.sv
`default_nettype none
package rlmt_pkg;
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic OpStart = 1'b0;
  localparam logic OpDone  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] request_id;
    logic [63:0] timestamp;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;
endpackage
`default_nettype wire

FILE: rtl/rlmt_front.sv
`default_nettype none
module rlmt_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           opcode_i,
  input  wire logic [63:0]    request_id_i,
  input  wire logic [63:0]    timestamp_i,
  output logic                busy_o,
  input  wire logic           pop_i,
  output logic                avail_o,
  output rlmt_pkg::item_t     item_o
);
  import rlmt_pkg::*;

  item_t       buf_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;

  assign busy_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rptr_q];
  assign push    = start_i && !busy_o;
  assign pop     = pop_i && avail_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= '{opcode: opcode_i, request_id: request_id_i, timestamp: timestamp_i};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rlmt_back.sv
`default_nettype none
module rlmt_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            avail_i,
  input  wire rlmt_pkg::item_t item_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic                 found_o,
  output logic                 table_full_o,
  output logic [63:0]          elapsed_o,
  output logic                 new_maximum_o,
  output logic [63:0]          max_elapsed_o,
  output logic [63:0]          max_request_id_o
);
  import rlmt_pkg::*;

  logic [63:0] key_mem  [TableEntries];
  logic [63:0] time_mem [TableEntries];

  state_e          state_q, state_d;
  item_t           cur_q;
  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] idx_nx;
  logic            hit_q, hit_d;
  logic [63:0]     rd_key_q, rd_time_q;
  logic [63:0]     max_q, max_id_q;
  logic [63:0]     diff;
  logic            bigger;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic            full_now;

  assign idx_nx   = idx_q + CntW'(1);
  assign pop_o    = (state_q == S_IDLE) && avail_i;
  assign diff     = cur_q.timestamp - rd_time_q;
  assign bigger   = diff > max_q;
  assign full_now = (fill_q == CntW'(TableEntries));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    case (state_q)
      S_IDLE: begin
        if (avail_i) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = (fill_q == '0) ? S_FIN : S_READ;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (rd_key_q == cur_q.request_id) begin
          hit_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          idx_d   = idx_nx;
          state_d = (idx_nx == fill_q) ? S_FIN : S_READ;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx_q[IdxW-1:0];
    if (state_q == S_FIN && cur_q.opcode == OpStart) begin
      if (hit_q) begin
        wr_en = 1'b1;
      end else if (!full_now) begin
        wr_en  = 1'b1;
        wr_idx = fill_q[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      idx_q            <= '0;
      hit_q            <= 1'b0;
      fill_q           <= '0;
      max_q            <= '0;
      max_id_q         <= '0;
      done_o           <= 1'b0;
      found_o          <= 1'b0;
      table_full_o     <= 1'b0;
      elapsed_o        <= '0;
      new_maximum_o    <= 1'b0;
      max_elapsed_o    <= '0;
      max_request_id_o <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hit_q   <= hit_d;
      done_o  <= (state_q == S_FIN);
      if (state_q == S_FIN) begin
        found_o          <= 1'b0;
        table_full_o     <= 1'b0;
        elapsed_o        <= '0;
        new_maximum_o    <= 1'b0;
        max_elapsed_o    <= max_q;
        max_request_id_o <= max_id_q;
        if (cur_q.opcode == OpStart) begin
          if (!hit_q) begin
            if (full_now) table_full_o <= 1'b1;
            else fill_q <= fill_q + CntW'(1);
          end
        end else if (hit_q) begin
          found_o   <= 1'b1;
          elapsed_o <= diff;
          if (bigger) begin
            new_maximum_o    <= 1'b1;
            max_q            <= diff;
            max_id_q         <= cur_q.request_id;
            max_elapsed_o    <= diff;
            max_request_id_o <= cur_q.request_id;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= item_i;
    if (state_q == S_READ) begin
      rd_key_q  <= key_mem[idx_q[IdxW-1:0]];
      rd_time_q <= time_mem[idx_q[IdxW-1:0]];
    end
    if (wr_en) begin
      key_mem[wr_idx]  <= cur_q.request_id;
      time_mem[wr_idx] <= cur_q.timestamp;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TableEntries)) else $error("fill count overflow");
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FIN)) else $error("result without finish");
  a_found_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(found_o && table_full_o)) else $error("found and full together");
  a_newmax_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && new_maximum_o) |-> (found_o && max_elapsed_o == elapsed_o))
    else $error("new maximum inconsistent");
`endif
endmodule
`default_nettype wire

FILE: rtl/request_latency_max_tracker.sv
// Channel  | Direction | Handshake           | Payload
// item in  | input     | start_i && !busy_o  | opcode_i, request_id_i, timestamp_i
// result   | output    | done_o (one cycle)  | found_o, table_full_o, elapsed_o,
//          |           |                     | new_maximum_o, max_elapsed_o, max_request_id_o
// The back end pops an item in S_IDLE and passes S_READ and S_CMP for each table entry read
// (through the hit, or the whole fill on a miss), then S_FIN; the result strobes the cycle after.
// A two-entry queue takes up to two items while the back end works.
// Reset clears the fill count and maximum; the table needs no clearing pass.
// The receiver cannot stall; each result strobes for one cycle.
`default_nettype none
module request_latency_max_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        opcode_i,
  input  wire logic [63:0] request_id_i,
  input  wire logic [63:0] timestamp_i,
  output logic             done_o,
  output logic             found_o,
  output logic             table_full_o,
  output logic [63:0]      elapsed_o,
  output logic             new_maximum_o,
  output logic [63:0]      max_elapsed_o,
  output logic [63:0]      max_request_id_o
);
  import rlmt_pkg::*;

  item_t item;
  logic  avail;
  logic  pop;

  rlmt_front u_front (
    .clk_i, .rst_ni, .start_i, .opcode_i, .request_id_i, .timestamp_i,
    .busy_o, .pop_i(pop), .avail_o(avail), .item_o(item)
  );

  rlmt_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .item_i(item), .pop_o(pop),
    .done_o, .found_o, .table_full_o, .elapsed_o, .new_maximum_o,
    .max_elapsed_o, .max_request_id_o
  );
endmodule
`default_nettype wire

FILE: tb/tb_request_latency_max_tracker.sv
`default_nettype none
module tb_request_latency_max_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import rlmt_pkg::*;

  typedef struct {
    logic        found;
    logic        table_full;
    logic [63:0] elapsed;
    logic        new_maximum;
    logic [63:0] max_elapsed;
    logic [63:0] max_request_id;
  } latency_result_t;

  class latency_scoreboard;
    logic [63:0]     start_time_by_id[logic [63:0]];
    logic [63:0]     peak_elapsed;
    logic [63:0]     peak_id;
    latency_result_t pending[$];
    int              mismatches;

    function new();
      peak_elapsed = '0;
      peak_id      = '0;
      mismatches   = 0;
    endfunction

    function void note_item(logic op, logic [63:0] id, logic [63:0] ts);
      latency_result_t r;
      r = '{1'b0, 1'b0, 64'd0, 1'b0, 64'd0, 64'd0};
      if (op == OpStart) begin
        if (start_time_by_id.exists(id) || start_time_by_id.num() < TableEntries) begin
          start_time_by_id[id] = ts;
        end else begin
          r.table_full = 1'b1;
        end
      end else if (start_time_by_id.exists(id)) begin
        r.found   = 1'b1;
        r.elapsed = ts - start_time_by_id[id];
        if (r.elapsed > peak_elapsed) begin
          peak_elapsed  = r.elapsed;
          peak_id       = id;
          r.new_maximum = 1'b1;
        end
      end
      r.max_elapsed    = peak_elapsed;
      r.max_request_id = peak_id;
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
    endtask

    task check_result(latency_result_t got);
      latency_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 64'd0, 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found) report("found", 64'(got.found), 64'(want.found));
      if (got.table_full !== want.table_full)
        report("table_full", 64'(got.table_full), 64'(want.table_full));
      if (got.elapsed !== want.elapsed) report("elapsed", got.elapsed, want.elapsed);
      if (got.new_maximum !== want.new_maximum)
        report("new_maximum", 64'(got.new_maximum), 64'(want.new_maximum));
      if (got.max_elapsed !== want.max_elapsed)
        report("max_elapsed", got.max_elapsed, want.max_elapsed);
      if (got.max_request_id !== want.max_request_id)
        report("max_request_id", got.max_request_id, want.max_request_id);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        opcode_i;
  logic [63:0] request_id_i;
  logic [63:0] timestamp_i;
  logic        done_o;
  logic        found_o;
  logic        table_full_o;
  logic [63:0] elapsed_o;
  logic        new_maximum_o;
  logic [63:0] max_elapsed_o;
  logic [63:0] max_request_id_o;

  latency_scoreboard sb;
  logic [63:0]       id_pool[32];
  logic [63:0]       pool_time[32];
  int unsigned       cycles;

  request_latency_max_tracker i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .opcode_i,
    .request_id_i,
    .timestamp_i,
    .done_o,
    .found_o,
    .table_full_o,
    .elapsed_o,
    .new_maximum_o,
    .max_elapsed_o,
    .max_request_id_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("[request_latency_max_tracker] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    latency_result_t r;
    if (rst_ni && done_o) begin
      r.found          = found_o;
      r.table_full     = table_full_o;
      r.elapsed        = elapsed_o;
      r.new_maximum    = new_maximum_o;
      r.max_elapsed    = max_elapsed_o;
      r.max_request_id = max_request_id_o;
      sb.check_result(r);
    end
  end

  task send_item(logic op, logic [63:0] id, logic [63:0] ts);
    start_i      <= 1'b1;
    opcode_i     <= op;
    request_id_i <= id;
    timestamp_i  <= ts;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(op, id, ts);
  endtask

  task idle_gap();
    int n;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int          k;
    logic        op;
    logic [63:0] id;
    logic [63:0] ts;
    sb           = new();
    cycles       = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    opcode_i     = 1'b0;
    request_id_i = '0;
    timestamp_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, unknown id, wrap, overwrite, tie, zero elapsed
    send_item(OpDone, 64'd5, 64'd100);
    send_item(OpStart, 64'd0, 64'd0);
    send_item(OpStart, '1, '1);
    send_item(OpDone, '1, 64'd0);
    send_item(OpDone, 64'd0, 64'd0);
    send_item(OpDone, 64'd0, 64'd7);
    send_item(OpDone, 64'd0, 64'd7);
    send_item(OpStart, 64'd0, 64'd3);
    send_item(OpDone, 64'd0, 64'd3);
    send_item(OpDone, 64'd0, 64'd2);
    send_item(OpStart, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OpDone, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_item(OpDone, 64'hAAAA_AAAA_AAAA_AAAA, '1);
    send_item(OpStart, 64'd1, 64'd10);
    send_item(OpStart, 64'd1, 64'd20);
    send_item(OpDone, 64'd1, 64'd25);
    drain();

    foreach (id_pool[i]) begin
      id_pool[i]   = rand64();
      pool_time[i] = rand64();
    end
    for (k = 0; k < 550; k++) begin
      if (k == 275) drain();
      op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 88) begin
        int p;
        p  = $urandom_range(0, 31);
        id = id_pool[p];
        if (op == OpStart) begin
          ts = ($urandom_range(0, 3) == 0) ? rand64() : pool_time[p];
          pool_time[p] = ts;
        end else begin
          ts = ($urandom_range(0, 3) == 0) ? rand64()
                                           : pool_time[p] + $urandom_range(0, 100000) * k;
        end
      end else begin
        id = rand64();
        ts = rand64();
      end
      send_item(op, id, ts);
      idle_gap();
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[request_latency_max_tracker] OK");
    end else begin
      $display("[request_latency_max_tracker] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/rlmt_pkg.sv
rtl/rlmt_front.sv
rtl/rlmt_back.sv
rtl/request_latency_max_tracker.sv
tb/tb_request_latency_max_tracker.sv
